>>> hw/rtl/qbr_pkg.sv
package qbr_pkg;

  // result status codes
  localparam logic [1:0] ST_PIXEL  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  // input op codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

  // wide operand of the shared multiplier
  localparam logic [3:0] A_SD01X = 4'd0;  // s*(x0-x1)
  localparam logic [3:0] A_SD21X = 4'd1;  // s*(x2-x1)
  localparam logic [3:0] A_X2S   = 4'd2;  // 2*s*x
  localparam logic [3:0] A_X     = 4'd3;
  localparam logic [3:0] A_Y     = 4'd4;
  localparam logic [3:0] A_YY    = 4'd5;
  localparam logic [3:0] A_XY    = 4'd6;
  localparam logic [3:0] A_CUR   = 4'd7;
  localparam logic [3:0] A_XX    = 4'd8;

  // narrow operand of the shared multiplier
  localparam logic [3:0] B_D21Y = 4'd0;
  localparam logic [3:0] B_D01Y = 4'd1;
  localparam logic [3:0] B_Y    = 4'd2;
  localparam logic [3:0] B_X    = 4'd3;
  localparam logic [3:0] B_N01X = 4'd4;   // 1-2|x0-x1|
  localparam logic [3:0] B_M01Y = 4'd5;   // |y0-y1|
  localparam logic [3:0] B_T02Y = 4'd6;   // 2|y0-y2|
  localparam logic [3:0] B_N01Y = 4'd7;
  localparam logic [3:0] B_M01X = 4'd8;
  localparam logic [3:0] B_T02X = 4'd9;
  localparam logic [3:0] B_N21X = 4'd10;
  localparam logic [3:0] B_M21Y = 4'd11;
  localparam logic [3:0] B_N21Y = 4'd12;
  localparam logic [3:0] B_M21X = 4'd13;

  // destination of a product
  localparam logic [2:0] D_CUR = 3'd0;
  localparam logic [2:0] D_XY  = 3'd1;
  localparam logic [2:0] D_XX  = 3'd2;
  localparam logic [2:0] D_YY  = 3'd3;
  localparam logic [2:0] D_DX  = 3'd4;
  localparam logic [2:0] D_DY  = 3'd5;
  localparam logic [2:0] D_EX  = 3'd6;
  localparam logic [2:0] D_EY  = 3'd7;

  localparam logic [1:0] ACC_SET = 2'd0;
  localparam logic [1:0] ACC_ADD = 2'd1;
  localparam logic [1:0] ACC_SUB = 2'd2;

  localparam int NUM_UOPS = 17;

  typedef struct packed {
    logic [3:0] asel;
    logic [3:0] bsel;
    logic [2:0] dst;
    logic [1:0] acc;
  } uop_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  function automatic uop_t uop_lookup(input logic [4:0] k);
    uop_t u;
    case (k)
      5'd0:    u = '{A_SD01X, B_D21Y, D_CUR, ACC_SET};
      5'd1:    u = '{A_SD21X, B_D01Y, D_CUR, ACC_SUB};
      5'd2:    u = '{A_X2S,   B_Y,    D_XY,  ACC_SET};
      5'd3:    u = '{A_X,     B_X,    D_XX,  ACC_SET};
      5'd4:    u = '{A_Y,     B_Y,    D_YY,  ACC_SET};
      5'd5:    u = '{A_YY,    B_N01X, D_DX,  ACC_SET};
      5'd6:    u = '{A_XY,    B_M01Y, D_DX,  ACC_ADD};
      5'd7:    u = '{A_CUR,   B_T02Y, D_DX,  ACC_SUB};
      5'd8:    u = '{A_XX,    B_N01Y, D_DY,  ACC_SET};
      5'd9:    u = '{A_XY,    B_M01X, D_DY,  ACC_ADD};
      5'd10:   u = '{A_CUR,   B_T02X, D_DY,  ACC_ADD};
      5'd11:   u = '{A_YY,    B_N21X, D_EX,  ACC_SET};
      5'd12:   u = '{A_XY,    B_M21Y, D_EX,  ACC_ADD};
      5'd13:   u = '{A_CUR,   B_T02Y, D_EX,  ACC_ADD};
      5'd14:   u = '{A_XX,    B_N21Y, D_EY,  ACC_SET};
      5'd15:   u = '{A_XY,    B_M21X, D_EY,  ACC_ADD};
      5'd16:   u = '{A_CUR,   B_T02X, D_EY,  ACC_SUB};
      default: u = '{A_X,     B_X,    D_XX,  ACC_SET};
    endcase
    return u;
  endfunction

endpackage

>>> hw/rtl/qbr_if.sv
interface qbr_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  op;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] ctrl_x;
  logic [COORD_BITS-1:0] ctrl_y;
  logic [COORD_BITS-1:0] stop_x;
  logic [COORD_BITS-1:0] stop_y;

  modport source (output valid, op, start_x, start_y, ctrl_x, ctrl_y, stop_x, stop_y,
                  input ready);
  modport sink (input valid, op, start_x, start_y, ctrl_x, ctrl_y, stop_x, stop_y,
                output ready);
endinterface

interface qbr_out_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [1:0]            status;
  logic                  last_pixel;

  modport source (output valid, pixel_x, pixel_y, status, last_pixel, input ready);
  modport sink (input valid, pixel_x, pixel_y, status, last_pixel, output ready);
endinterface

>>> hw/rtl/qbr_mul.sv
// Shift-add signed multiplier: one bit of b per cycle, MSB of b weighs negative.
module qbr_mul #(
  parameter int WA = 48,
  parameter int WB = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [WA-1:0]  a,
  input  logic signed [WB-1:0]  b,
  output qbr_pkg::mul_stat_t    stat,
  output logic signed [WA-1:0]  p
);

  localparam int CW = $clog2(WB);

  logic              busy_r;
  logic              done_r;
  logic [CW-1:0]     cnt_r;
  logic signed [WA-1:0] a_r;
  logic [WB-1:0]     b_r;
  logic signed [WA-1:0] acc_r;
  logic signed [WA-1:0] term;

  assign term = b_r[0] ? a_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(WB - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= (cnt_r == CW'(WB - 1)) ? acc_r - term : acc_r + term;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign p         = acc_r;

endmodule

>>> hw/rtl/quadratic_bezier_rasterizer.sv
// Quadratic Bezier segment rasterizer, one pixel per transaction.
// in_ch: op=start loads P0 (start), P1 (ctrl), P2 (stop) and returns P0;
//   op=next returns the following pixel, last_pixel marks the curve end.
//   A start whose gradient sign changes returns status rejected; a next with
//   no curve active returns status idle.
// out_ch: one result per accepted input transaction, held in an output
//   register until taken; a stalled receiver holds the block in its final
//   state, and in_ch.ready stays low until the result register is free.
// Flow: a next transaction runs one or two add/compare steps of the error
//   walk, then loads the result register; an idle next or a rejected start
//   goes straight to the result register. A start transaction runs 17
//   products through one shift-add multiplier (a COORD_BITS+2 bit narrow
//   operand each), then compare and fix-up and the first walk step.
// One transaction is in flight at a time; in_ch.ready is high only in idle.
// Reset: synchronous, active low; no curve is active and the output is empty.
module quadratic_bezier_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int ERR_BITS   = 48
) (
  input  logic  clk,
  input  logic  rst_n,
  qbr_in_if.sink    in_ch,
  qbr_out_if.source out_ch
);

  localparam int CB = COORD_BITS;
  localparam int EB = ERR_BITS;
  localparam int MB = COORD_BITS + 2;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_MUL_GO   = 3'd1;
  localparam logic [2:0] S_MUL_WAIT = 3'd2;
  localparam logic [2:0] S_FIN_A    = 3'd3;
  localparam logic [2:0] S_FIN_B    = 3'd4;
  localparam logic [2:0] S_ADV1     = 3'd5;
  localparam logic [2:0] S_ADV2     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  localparam logic [1:0] M_IDLE  = 2'd0;
  localparam logic [1:0] M_LINE  = 2'd1;
  localparam logic [1:0] M_LINE1 = 2'd2;
  localparam logic [1:0] M_CURVE = 2'd3;

  logic [2:0] state_r;
  logic [1:0] mode_r;
  logic [4:0] k_r;

  logic [CB-1:0] pos_x_r, pos_y_r, goal_x_r, goal_y_r, mid_x_r, mid_y_r;
  logic          dir_neg_x_r, dir_neg_y_r;
  logic signed [EB-1:0] incr_x_r, incr_y_r, err_r, cross_r, secx_r, secy_r;
  logic signed [EB-1:0] cur_r, ey_r;
  logic          cy_r;

  logic [CB-1:0] res_x_r, res_y_r;
  logic [1:0]    res_st_r;
  logic          res_last_r;

  logic          out_vld_r;
  logic [CB-1:0] out_x_r, out_y_r;
  logic [1:0]    out_st_r;
  logic          out_last_r;

  logic in_acc;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // start-time reject check on the raw inputs
  logic rej_x, rej_y, reject;
  assign rej_x = (in_ch.start_x > in_ch.ctrl_x && in_ch.stop_x > in_ch.ctrl_x) ||
                 (in_ch.start_x < in_ch.ctrl_x && in_ch.stop_x < in_ch.ctrl_x);
  assign rej_y = (in_ch.start_y > in_ch.ctrl_y && in_ch.stop_y > in_ch.ctrl_y) ||
                 (in_ch.start_y < in_ch.ctrl_y && in_ch.stop_y < in_ch.ctrl_y);
  assign reject = rej_x || rej_y;

  // small setup terms from P0 (=pos during setup), P1, P2
  logic signed [CB:0]   d01x, d01y, d21x, d21y;
  logic signed [CB+1:0] xc, yc;
  logic [CB-1:0] m01x, m01y, m21x, m21y, m02x, m02y;
  logic sneg;

  assign d01x = $signed({1'b0, pos_x_r}) - $signed({1'b0, mid_x_r});
  assign d01y = $signed({1'b0, pos_y_r}) - $signed({1'b0, mid_y_r});
  assign d21x = $signed({1'b0, goal_x_r}) - $signed({1'b0, mid_x_r});
  assign d21y = $signed({1'b0, goal_y_r}) - $signed({1'b0, mid_y_r});
  assign xc = $signed({2'b00, pos_x_r}) - $signed({1'b0, mid_x_r, 1'b0})
              + $signed({2'b00, goal_x_r});
  assign yc = $signed({2'b00, pos_y_r}) - $signed({1'b0, mid_y_r, 1'b0})
              + $signed({2'b00, goal_y_r});
  assign m01x = (pos_x_r > mid_x_r) ? pos_x_r - mid_x_r : mid_x_r - pos_x_r;
  assign m01y = (pos_y_r > mid_y_r) ? pos_y_r - mid_y_r : mid_y_r - pos_y_r;
  assign m21x = (goal_x_r > mid_x_r) ? goal_x_r - mid_x_r : mid_x_r - goal_x_r;
  assign m21y = (goal_y_r > mid_y_r) ? goal_y_r - mid_y_r : mid_y_r - goal_y_r;
  assign m02x = (pos_x_r > goal_x_r) ? pos_x_r - goal_x_r : goal_x_r - pos_x_r;
  assign m02y = (pos_y_r > goal_y_r) ? pos_y_r - goal_y_r : goal_y_r - pos_y_r;
  assign sneg = dir_neg_x_r ^ dir_neg_y_r;

  qbr_pkg::uop_t uop;
  assign uop = qbr_pkg::uop_lookup(k_r);

  logic signed [EB-1:0] mul_a, mul_p, mul_acc;
  logic signed [MB-1:0] mul_b;
  qbr_pkg::mul_stat_t   mst;

  always_comb begin
    case (uop.asel)
      qbr_pkg::A_SD01X: mul_a = sneg ? -EB'(d01x) : EB'(d01x);
      qbr_pkg::A_SD21X: mul_a = sneg ? -EB'(d21x) : EB'(d21x);
      qbr_pkg::A_X2S:   mul_a = sneg ? -(EB'(xc) <<< 1) : (EB'(xc) <<< 1);
      qbr_pkg::A_X:     mul_a = EB'(xc);
      qbr_pkg::A_Y:     mul_a = EB'(yc);
      qbr_pkg::A_YY:    mul_a = secy_r;
      qbr_pkg::A_XY:    mul_a = cross_r;
      qbr_pkg::A_CUR:   mul_a = cur_r;
      qbr_pkg::A_XX:    mul_a = secx_r;
      default:          mul_a = '0;
    endcase
  end

  always_comb begin
    case (uop.bsel)
      qbr_pkg::B_D21Y: mul_b = MB'(d21y);
      qbr_pkg::B_D01Y: mul_b = MB'(d01y);
      qbr_pkg::B_Y:    mul_b = yc;
      qbr_pkg::B_X:    mul_b = xc;
      qbr_pkg::B_N01X: mul_b = $signed(MB'(1)) - $signed({1'b0, m01x, 1'b0});
      qbr_pkg::B_M01Y: mul_b = $signed({2'b00, m01y});
      qbr_pkg::B_T02Y: mul_b = $signed({1'b0, m02y, 1'b0});
      qbr_pkg::B_N01Y: mul_b = $signed(MB'(1)) - $signed({1'b0, m01y, 1'b0});
      qbr_pkg::B_M01X: mul_b = $signed({2'b00, m01x});
      qbr_pkg::B_T02X: mul_b = $signed({1'b0, m02x, 1'b0});
      qbr_pkg::B_N21X: mul_b = $signed(MB'(1)) - $signed({1'b0, m21x, 1'b0});
      qbr_pkg::B_M21Y: mul_b = $signed({2'b00, m21y});
      qbr_pkg::B_N21Y: mul_b = $signed(MB'(1)) - $signed({1'b0, m21y, 1'b0});
      qbr_pkg::B_M21X: mul_b = $signed({2'b00, m21x});
      default:         mul_b = '0;
    endcase
  end

  qbr_mul #(.WA(EB), .WB(MB)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_MUL_GO),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mst),
    .p     (mul_p)
  );

  // current value of the product's destination, for accumulate
  logic signed [EB-1:0] dst_old;
  always_comb begin
    case (uop.dst)
      qbr_pkg::D_CUR: dst_old = cur_r;
      qbr_pkg::D_XY:  dst_old = cross_r;
      qbr_pkg::D_XX:  dst_old = secx_r;
      qbr_pkg::D_YY:  dst_old = secy_r;
      qbr_pkg::D_DX:  dst_old = incr_x_r;
      qbr_pkg::D_DY:  dst_old = incr_y_r;
      qbr_pkg::D_EX:  dst_old = err_r;
      qbr_pkg::D_EY:  dst_old = ey_r;
      default:        dst_old = '0;
    endcase
    case (uop.acc)
      qbr_pkg::ACC_ADD: mul_acc = dst_old + mul_p;
      qbr_pkg::ACC_SUB: mul_acc = dst_old - mul_p;
      default:          mul_acc = mul_p;
    endcase
  end

  // line setup from pos toward P1 (during curve fix-up) or P2
  logic [CB-1:0] ls_tx, ls_ty, ls_mx, ls_my;
  logic          ls_nx, ls_ny;
  logic signed [EB-1:0] ls_ix, ls_iy;
  assign ls_tx = (state_r == S_FIN_B) ? mid_x_r : goal_x_r;
  assign ls_ty = (state_r == S_FIN_B) ? mid_y_r : goal_y_r;
  assign ls_nx = !(pos_x_r < ls_tx);
  assign ls_ny = !(pos_y_r < ls_ty);
  assign ls_mx = ls_nx ? pos_x_r - ls_tx : ls_tx - pos_x_r;
  assign ls_my = ls_ny ? pos_y_r - ls_ty : ls_ty - pos_y_r;
  assign ls_ix = $signed(EB'(ls_mx));
  assign ls_iy = -$signed(EB'(ls_my));

  // walk terms
  logic [CB-1:0] ln_tx, ln_ty, step_x, step_y;
  logic signed [EB-1:0] e2, sum_iy, sum_ix;
  logic ln_end, lc1, lc2, ccx, ccy, near_line;
  assign ln_tx  = (mode_r == M_LINE1) ? mid_x_r : goal_x_r;
  assign ln_ty  = (mode_r == M_LINE1) ? mid_y_r : goal_y_r;
  assign ln_end = (pos_x_r == ln_tx) && (pos_y_r == ln_ty);
  assign e2     = err_r <<< 1;
  assign lc1    = (e2 >= incr_y_r);
  assign lc2    = (e2 <= incr_x_r);
  assign ccx    = (e2 >= incr_x_r);
  assign ccy    = ((e2 - incr_y_r) <= 0);
  assign step_x = dir_neg_x_r ? pos_x_r - CB'(1) : pos_x_r + CB'(1);
  assign step_y = dir_neg_y_r ? pos_y_r - CB'(1) : pos_y_r + CB'(1);
  assign sum_iy = lc1 ? incr_y_r : '0;
  assign sum_ix = lc2 ? incr_x_r : '0;
  assign near_line = (incr_x_r >= -secy_r) || (incr_y_r <= -secx_r) ||
                     (err_r <= -secy_r) || (ey_r >= -secx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= M_IDLE;
      k_r         <= '0;
      pos_x_r     <= '0;
      pos_y_r     <= '0;
      goal_x_r    <= '0;
      goal_y_r    <= '0;
      mid_x_r     <= '0;
      mid_y_r     <= '0;
      dir_neg_x_r <= 1'b0;
      dir_neg_y_r <= 1'b0;
      incr_x_r    <= '0;
      incr_y_r    <= '0;
      err_r       <= '0;
      cross_r     <= '0;
      secx_r      <= '0;
      secy_r      <= '0;
      out_vld_r   <= 1'b0;
    end else begin
      if (out_vld_r && out_ch.ready && state_r != S_DONE) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_last_r <= 1'b0;
            if (in_ch.op == qbr_pkg::OP_START) begin
              mode_r  <= M_IDLE;
              res_x_r <= '0;
              res_y_r <= '0;
              if (reject) begin
                res_st_r <= qbr_pkg::ST_REJECT;
                state_r  <= S_DONE;
              end else begin
                res_st_r    <= qbr_pkg::ST_PIXEL;
                pos_x_r     <= in_ch.start_x;
                pos_y_r     <= in_ch.start_y;
                mid_x_r     <= in_ch.ctrl_x;
                mid_y_r     <= in_ch.ctrl_y;
                goal_x_r    <= in_ch.stop_x;
                goal_y_r    <= in_ch.stop_y;
                dir_neg_x_r <= !(in_ch.start_x < in_ch.stop_x);
                dir_neg_y_r <= !(in_ch.start_y < in_ch.stop_y);
                k_r         <= '0;
                state_r     <= S_MUL_GO;
              end
            end else if (mode_r == M_IDLE) begin
              res_x_r  <= '0;
              res_y_r  <= '0;
              res_st_r <= qbr_pkg::ST_IDLE;
              state_r  <= S_DONE;
            end else begin
              res_x_r  <= pos_x_r;
              res_y_r  <= pos_y_r;
              res_st_r <= qbr_pkg::ST_PIXEL;
              state_r  <= S_ADV1;
            end
          end
        end
        S_MUL_GO: state_r <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mst.done) begin
            case (uop.dst)
              qbr_pkg::D_CUR: cur_r    <= mul_acc;
              qbr_pkg::D_XY:  cross_r  <= mul_acc;
              qbr_pkg::D_XX:  secx_r   <= mul_acc;
              qbr_pkg::D_YY:  secy_r   <= mul_acc;
              qbr_pkg::D_DX:  incr_x_r <= mul_acc;
              qbr_pkg::D_DY:  incr_y_r <= mul_acc;
              qbr_pkg::D_EX:  err_r    <= mul_acc;
              default:        ey_r     <= mul_acc;
            endcase
            k_r <= k_r + 5'd1;
            state_r <= (k_r == 5'(qbr_pkg::NUM_UOPS - 1)) ? S_FIN_A : S_MUL_GO;
          end
        end
        S_FIN_A: begin
          res_x_r <= pos_x_r;
          res_y_r <= pos_y_r;
          if (cur_r == '0) begin
            dir_neg_x_r <= ls_nx;
            dir_neg_y_r <= ls_ny;
            incr_x_r    <= ls_ix;
            incr_y_r    <= ls_iy;
            err_r       <= ls_ix + ls_iy;
            mode_r      <= M_LINE;
            state_r     <= S_ADV1;
          end else begin
            // flip all terms but cur_r for negative curvature
            if (cur_r < 0) begin
              secx_r   <= -(secx_r <<< 1);
              secy_r   <= -(secy_r <<< 1);
              cross_r  <= -cross_r;
              incr_x_r <= -incr_x_r;
              incr_y_r <= -incr_y_r;
              err_r    <= -err_r;
              ey_r     <= -ey_r;
            end else begin
              secx_r <= secx_r <<< 1;
              secy_r <= secy_r <<< 1;
            end
            state_r <= S_FIN_B;
          end
        end
        S_FIN_B: begin
          if (near_line) begin
            dir_neg_x_r <= ls_nx;
            dir_neg_y_r <= ls_ny;
            incr_x_r    <= ls_ix;
            incr_y_r    <= ls_iy;
            err_r       <= ls_ix + ls_iy;
            mode_r      <= M_LINE1;
          end else begin
            incr_x_r <= incr_x_r - cross_r;
            incr_y_r <= incr_y_r - cross_r;
            err_r    <= incr_x_r + incr_y_r - cross_r;
            mode_r   <= M_CURVE;
          end
          state_r <= S_ADV1;
        end
        S_ADV1: begin
          if (mode_r == M_CURVE) begin
            cy_r <= ccy;
            if (ccx) begin
              if (pos_x_r == goal_x_r) begin
                res_last_r <= 1'b1;
                mode_r     <= M_IDLE;
                state_r    <= S_DONE;
              end else begin
                pos_x_r  <= step_x;
                incr_y_r <= incr_y_r - cross_r;
                incr_x_r <= incr_x_r + secy_r;
                err_r    <= err_r + incr_x_r + secy_r;
                state_r  <= S_ADV2;
              end
            end else begin
              state_r <= S_ADV2;
            end
          end else begin
            state_r <= S_DONE;
            if (ln_end) begin
              if (mode_r == M_LINE1) begin
                // second leg: P1 to P2, P1 comes out again
                dir_neg_x_r <= ls_nx;
                dir_neg_y_r <= ls_ny;
                incr_x_r    <= ls_ix;
                incr_y_r    <= ls_iy;
                err_r       <= ls_ix + ls_iy;
                mode_r      <= M_LINE;
              end else begin
                res_last_r <= 1'b1;
                mode_r     <= M_IDLE;
              end
            end else begin
              err_r <= err_r + sum_iy + sum_ix;
              if (lc1) pos_x_r <= step_x;
              if (lc2) pos_y_r <= step_y;
            end
          end
        end
        S_ADV2: begin
          if (cy_r) begin
            if (pos_y_r == goal_y_r) begin
              res_last_r <= 1'b1;
              mode_r     <= M_IDLE;
            end else begin
              pos_y_r  <= step_y;
              incr_x_r <= incr_x_r - cross_r;
              incr_y_r <= incr_y_r + secx_r;
              err_r    <= err_r + incr_y_r + secx_r;
            end
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_vld_r || out_ch.ready) begin
            out_vld_r  <= 1'b1;
            out_x_r    <= res_x_r;
            out_y_r    <= res_y_r;
            out_st_r   <= res_st_r;
            out_last_r <= res_last_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.pixel_x    = out_x_r;
  assign out_ch.pixel_y    = out_y_r;
  assign out_ch.status     = out_st_r;
  assign out_ch.last_pixel = out_last_r;

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mst.done |-> state_r == S_MUL_WAIT)
    else $error("multiplier finished outside its wait state");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted transaction did not start work");

  a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && (!out_vld_r || out_ch.ready)) |=> out_vld_r)
    else $error("finished result not loaded into output register");

  a_last_only_on_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_last_r) |-> res_st_r == qbr_pkg::ST_PIXEL)
    else $error("last pixel flagged on a non-pixel result");

endmodule

>>> tb/quadratic_bezier_rasterizer_tb.sv
`timescale 1ns / 100ps

module quadratic_bezier_rasterizer_tb;

  localparam int CW = 12;
  localparam int IDLE_LIMIT = 5000;

  typedef logic [CW-1:0] coord_t;
  typedef enum logic [1:0] {WALK_IDLE, WALK_LINE, WALK_LINE1, WALK_CURVE} walk_t;

  typedef struct {
    coord_t     x;
    coord_t     y;
    logic [1:0] status;
    logic       last;
  } pixel_t;

  // Tracks the rasterizer state and holds the pixels still owed by the block.
  class pixel_scoreboard;
    pixel_t  owed[$];
    int      errors;
    coord_t  cx, cy, tx, ty, mx, my;
    bit      neg_x, neg_y;
    longint  inc_x, inc_y, err, xy_t, dd_x, dd_y;
    walk_t   walk;

    function new();
      errors = 0;
      cx = '0; cy = '0; tx = '0; ty = '0; mx = '0; my = '0;
      neg_x = 0; neg_y = 0;
      inc_x = 0; inc_y = 0; err = 0; xy_t = 0; dd_x = 0; dd_y = 0;
      walk = WALK_IDLE;
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function coord_t step1(coord_t p, bit neg);
      return neg ? p - 1'b1 : p + 1'b1;
    endfunction

    function void line_setup(coord_t gx, coord_t gy);
      longint x, y;
      x = longint'(cx);
      y = longint'(cy);
      neg_x = !(x < longint'(gx));
      neg_y = !(y < longint'(gy));
      inc_x = mag(longint'(gx) - x);
      inc_y = -mag(longint'(gy) - y);
      err = inc_x + inc_y;
    endfunction

    function bit line_step(coord_t gx, coord_t gy);
      longint e2;
      if (cx == gx && cy == gy) return 1;
      e2 = 2 * err;
      if (e2 >= inc_y) begin
        err += inc_y;
        cx = step1(cx, neg_x);
      end
      if (e2 <= inc_x) begin
        err += inc_x;
        cy = step1(cy, neg_y);
      end
      return 0;
    endfunction

    function bit curve_step();
      longint ey;
      ey = 2 * err - inc_y;
      if (2 * err >= inc_x) begin
        if (cx == tx) return 1;
        cx = step1(cx, neg_x);
        inc_y -= xy_t;
        inc_x += dd_y;
        err += inc_x;
      end
      if (ey <= 0) begin
        if (cy == ty) return 1;
        cy = step1(cy, neg_y);
        inc_x -= xy_t;
        inc_y += dd_x;
        err += inc_y;
      end
      return 0;
    endfunction

    function bit load_curve(longint x0, longint y0, longint x1, longint y1,
                            longint x2, longint y2);
      longint sx, sy, s, cur, x, y, xy, dx, dy, ex, ey;
      sx = x0 < x2 ? 1 : -1;
      sy = y0 < y2 ? 1 : -1;
      s = sx * sy;
      cur = s * ((x0 - x1) * (y2 - y1) - (x2 - x1) * (y0 - y1));
      x = x0 - 2 * x1 + x2;
      y = y0 - 2 * y1 + y2;
      xy = 2 * x * y * s;
      if ((x0 - x1) * (x2 - x1) > 0 || (y0 - y1) * (y2 - y1) > 0) return 0;
      dx = (1 - 2 * mag(x0 - x1)) * y * y + mag(y0 - y1) * xy - 2 * cur * mag(y0 - y2);
      dy = (1 - 2 * mag(y0 - y1)) * x * x + mag(x0 - x1) * xy + 2 * cur * mag(x0 - x2);
      ex = (1 - 2 * mag(x2 - x1)) * y * y + mag(y2 - y1) * xy + 2 * cur * mag(y0 - y2);
      ey = (1 - 2 * mag(y2 - y1)) * x * x + mag(x2 - x1) * xy - 2 * cur * mag(x0 - x2);
      cx = coord_t'(x0); cy = coord_t'(y0);
      mx = coord_t'(x1); my = coord_t'(y1);
      tx = coord_t'(x2); ty = coord_t'(y2);
      if (cur == 0) begin
        line_setup(tx, ty);
        walk = WALK_LINE;
        return 1;
      end
      x = 2 * x * x;
      y = 2 * y * y;
      if (cur < 0) begin
        x = -x; y = -y; xy = -xy; dx = -dx; dy = -dy; ex = -ex; ey = -ey;
      end
      // nearly straight: split into two lines through the middle point
      if (dx >= -y || dy <= -x || ex <= -y || ey >= -x) begin
        line_setup(mx, my);
        walk = WALK_LINE1;
        return 1;
      end
      dx -= xy;
      ex = dx + dy;
      dy -= xy;
      neg_x = sx < 0;
      neg_y = sy < 0;
      inc_x = dx; inc_y = dy; err = ex;
      xy_t = xy; dd_x = x; dd_y = y;
      walk = WALK_CURVE;
      return 1;
    endfunction

    function void note_input(logic op, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                             coord_t x2, coord_t y2);
      pixel_t p;
      bit last;
      p = '{x: '0, y: '0, status: qbr_pkg::ST_PIXEL, last: 1'b0};
      last = 0;
      if (op == qbr_pkg::OP_START) begin
        if (!load_curve(longint'(x0), longint'(y0), longint'(x1), longint'(y1),
                        longint'(x2), longint'(y2))) begin
          walk = WALK_IDLE;
          p.status = qbr_pkg::ST_REJECT;
          owed.push_back(p);
          return;
        end
      end else if (walk == WALK_IDLE) begin
        p.status = qbr_pkg::ST_IDLE;
        owed.push_back(p);
        return;
      end
      p.x = cx;
      p.y = cy;
      if (walk == WALK_LINE) begin
        last = line_step(tx, ty);
      end else if (walk == WALK_LINE1) begin
        if (line_step(mx, my)) begin
          line_setup(tx, ty);
          walk = WALK_LINE;
        end
      end else begin
        last = curve_step();
      end
      if (last) walk = WALK_IDLE;
      p.last = last;
      owed.push_back(p);
    endfunction

    function void report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void check_result(coord_t x, coord_t y, logic [1:0] status, logic last);
      pixel_t e;
      if (owed.size() == 0) begin
        report($sformatf("unexpected result x=%0d y=%0d status=%0d", x, y, status));
        return;
      end
      e = owed.pop_front();
      if (status !== e.status)
        report($sformatf("status %0d, expected %0d", status, e.status));
      if (x !== e.x) report($sformatf("pixel_x %0d, expected %0d", x, e.x));
      if (y !== e.y) report($sformatf("pixel_y %0d, expected %0d", y, e.y));
      if (last !== e.last) report($sformatf("last_pixel %0b, expected %0b", last, e.last));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qbr_in_if  #(.COORD_BITS(CW)) in_ch ();
  qbr_out_if #(.COORD_BITS(CW)) out_ch ();

  quadratic_bezier_rasterizer #(.COORD_BITS(CW), .ERR_BITS(48)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  pixel_scoreboard sb = new();
  int burst_left = 0;
  int quiet_cycles = 0;
  int cyc = 0;
  int items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.op = qbr_pkg::OP_NEXT;
    in_ch.start_x = '0; in_ch.start_y = '0;
    in_ch.ctrl_x = '0;  in_ch.ctrl_y = '0;
    in_ch.stop_x = '0;  in_ch.stop_y = '0;
    out_ch.ready = 1'b0;
  end

  // Receiver: checks each result and rotates through three stall styles (always ready, random, periodic).
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.pixel_x, out_ch.pixel_y, out_ch.status, out_ch.last_pixel);
      case ((cyc / 300) % 3)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default: out_ch.ready <= ((cyc % 16) < 5) ? 1'b0 : 1'b1;
      endcase
    end
  end

  // Watchdog on cycles with no transaction on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("quadratic_bezier_rasterizer regression: fail");
      $finish;
    end
  end

  task automatic send(logic op, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                      coord_t x2, coord_t y2);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.start_x <= x0; in_ch.start_y <= y0;
    in_ch.ctrl_x <= x1;  in_ch.ctrl_y <= y1;
    in_ch.stop_x <= x2;  in_ch.stop_y <= y2;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, x0, y0, x1, y1, x2, y2);
    items_sent++;
  endtask

  task automatic next_pixel();
    send(qbr_pkg::OP_NEXT, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
         coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
  endtask

  // Start a curve and walk it, giving up after max_steps (a later start abandons it).
  task automatic draw(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                      coord_t x2, coord_t y2, int max_steps);
    int n;
    n = 0;
    send(qbr_pkg::OP_START, x0, y0, x1, y1, x2, y2);
    while (sb.walk != WALK_IDLE && n < max_steps) begin
      next_pixel();
      n++;
    end
  endtask

  // Three sorted values with the middle one between, in a random direction.
  task automatic pick_axis(coord_t base, int span, output coord_t a, output coord_t b,
                           output coord_t c);
    int p, q, r, t;
    p = $urandom_range(0, span);
    q = $urandom_range(0, span);
    r = $urandom_range(0, span);
    if (p > r) begin t = p; p = r; r = t; end
    if (q < p) q = p;
    if (q > r) q = r;
    if ($urandom_range(0, 1)) begin
      a = base + coord_t'(p); b = base + coord_t'(q); c = base + coord_t'(r);
    end else begin
      a = base + coord_t'(r); b = base + coord_t'(q); c = base + coord_t'(p);
    end
  endtask

  initial begin
    coord_t ax, bx, cx, ay, by, cy;
    int span;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    next_pixel();                                   // idle request after reset
    draw('0, '0, '0, '0, '0, '0, 4);                // single-pixel line
    draw('1, '1, '1, '1, '1, '1, 4);
    draw(12'd10, 12'd10, 12'd20, 12'd20, 12'd30, 12'd25, 40);  // true curve
    draw(12'd0, 12'd0, 12'd1, 12'd0, 12'd6, 12'd2, 40);        // nearly straight
    draw(12'd0, 12'd0, 12'd0, 12'd12, 12'd12, 12'd12, 60);     // true curve
    send(qbr_pkg::OP_START, 12'd0, 12'd0, 12'd100, 12'd0, 12'd50, 12'd50);  // rejected
    next_pixel();
    draw(12'd4095, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, 3);   // abandoned
    send(qbr_pkg::OP_NEXT, '1, '1, '1, '1, '1, '1);
    draw(12'd0, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 2);
    next_pixel();

    while (items_sent < 450) begin
      case ($urandom_range(0, 9))
        0: next_pixel();
        1: draw(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                $urandom_range(0, 8));
        default: begin
          span = ($urandom_range(0, 4) == 0) ? 3 : 24;
          pick_axis(coord_t'($urandom_range(0, 4095 - span)), span, ax, bx, cx);
          pick_axis(coord_t'($urandom_range(0, 4095 - span)), span, ay, by, cy);
          draw(ax, ay, bx, by, cx, cy, $urandom_range(0, 3) == 0 ? 5 : 120);
        end
      endcase
    end

    in_ch.valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("quadratic_bezier_rasterizer regression: pass");
    end else begin
      $display("quadratic_bezier_rasterizer regression: fail");
    end
    $finish;
  end

endmodule
